// ===== rtl/core/sdl_pkg.sv =====
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared types, codes and sizes for the search/delete list core.
// ----------------------------------------------------------------------------
package sdl_pkg;

    localparam int DATA_W       = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int ENTRY_W      = 5;
    localparam int DEF_LIST_DEPTH = 16;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    // response status
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] key_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] found_value;
        logic [ENTRY_W-1:0]       entry_count;
    } t_rsp;

    // per-cell control, broadcast along the chain
    typedef struct packed {
        logic cmp;   // register match against the incoming key
        logic ins;   // shift one place toward the tail
        logic del;   // close the gap from the tail side, where selected
    } t_cell_ctl;

endpackage

// ===== rtl/core/sdl_cell.sv =====
// ----------------------------------------------------------------------------
// sdl_cell
// One list slot: holds a value, registers its match flag, shifts with its
// neighbours on insert and delete.
// ----------------------------------------------------------------------------
module sdl_cell
    import sdl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occ,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic                     i_sel,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_match
);

    logic signed [DATA_W-1:0] r_value;
    logic                     r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_value <= i_left;
        end else if (i_ctl.del && i_sel) begin
            r_value <= i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= i_occ && (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ===== rtl/core/sdl_prefix.sv =====
// ----------------------------------------------------------------------------
// sdl_prefix
// Inclusive prefix OR over the cell match flags (log-depth network).
// ----------------------------------------------------------------------------
module sdl_prefix #(
    parameter int N = 16
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_pre
);

    localparam int LV = (N > 1) ? $clog2(N) : 1;

    wire [N-1:0] w_lvl [0:LV];

    assign w_lvl[0] = i_bits;

    for (genvar k = 0; k < LV; k++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign w_lvl[k+1][i] = w_lvl[k][i] | w_lvl[k][i-(1<<k)];
            end else begin : g_pass
                assign w_lvl[k+1][i] = w_lvl[k][i];
            end
        end
    end

    assign o_pre = w_lvl[LV];

endmodule

// ===== rtl/core/search_delete_list_core.sv =====
// ----------------------------------------------------------------------------
// search_delete_list_core
// Bounded newest-first list of 32-bit values with insert, delete and search.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_req_valid / o_req_stall / i_req) carries an action and
//   a key. Response channel (o_rsp_valid / i_rsp_stall / o_rsp) returns one
//   response per request: status, found value, entries held afterwards.
//   Each request is a compare step and then an update step: at accept, every
//   cell of the chain registers a match flag and the busy flag is set; while
//   busy, the shift is applied and the response register is loaded, so a new
//   request is not taken on the cell chain before the last one is through.
//   The response turns valid as the response register is loaded.
//   A new request is held off while one is in flight, and while a response
//   waits under stall (the response register must be free to take the next).
//   While stalled the response holds steady.
//   Reset empties the list (count to zero) and clears both channels;
//   cell contents are left as they are and are never read beyond the count.
//   Action code 3 is answered with not-found and no change.
// ----------------------------------------------------------------------------
module search_delete_list_core
    import sdl_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    // control
    logic                     r_busy;
    logic [ACTION_W-1:0]      r_act;
    logic signed [DATA_W-1:0] r_key;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_rsp_valid;
    t_rsp                     r_rsp, n_rsp;

    logic                     w_acc;
    logic                     w_hit;
    logic                     w_full;
    t_cell_ctl                w_ctl;

    // chain wiring
    logic signed [DATA_W-1:0] w_val   [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]    w_match;
    logic [LIST_DEPTH-1:0]    w_pre;

    assign o_req_stall = r_busy | (r_rsp_valid & i_rsp_stall);
    assign w_acc       = i_req_valid & ~o_req_stall;

    assign w_hit  = w_pre[LIST_DEPTH-1];
    assign w_full = (r_count == CW'(LIST_DEPTH));

    // execute cycle: decide shift and response
    always_comb begin
        w_ctl     = '0;
        w_ctl.cmp = w_acc;
        n_count   = r_count;
        n_rsp     = '0;
        n_rsp.status = ST_MISS;
        case (r_act)
            ACT_INSERT: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    w_ctl.ins    = r_busy;
                    n_count      = r_count + CW'(1);
                    n_rsp.status = ST_DONE;
                end
            end
            ACT_DELETE: begin
                if (w_hit) begin
                    w_ctl.del    = r_busy;
                    n_count      = r_count - CW'(1);
                    n_rsp.status = ST_DONE;
                end
            end
            ACT_SEARCH: begin
                if (w_hit) begin
                    // a hit means the held value equals the key
                    n_rsp.found_value = r_key;
                    n_rsp.status      = ST_DONE;
                end
            end
            default: begin
                n_rsp.status = ST_MISS;
            end
        endcase
        n_rsp.entry_count = ENTRY_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_busy) begin
                r_busy      <= 1'b0;
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else begin
                if (w_acc) begin
                    r_busy <= 1'b1;
                end
                if (r_rsp_valid && !i_rsp_stall) begin
                    r_rsp_valid <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_act <= i_req.action;
            r_key <= i_req.key_value;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // cell chain: slot 0 is the head
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        logic                     w_occ;

        if (i == 0) begin : g_head
            assign w_left = r_key;
        end else begin : g_mid_l
            assign w_left = w_val[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_tail
            assign w_right = w_val[i];
        end else begin : g_mid_r
            assign w_right = w_val[i+1];
        end

        assign w_occ = (r_count > CW'(i));

        sdl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_occ   (w_occ),
            .i_key   (i_req.key_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_sel   (w_pre[i]),
            .o_value (w_val[i]),
            .o_match (w_match[i])
        );
    end

    // first-match select: cells at and behind the first match close the gap
    sdl_prefix #(
        .N (LIST_DEPTH)
    ) u_prefix (
        .i_bits (w_match),
        .o_pre  (w_pre)
    );

endmodule

// ===== rtl/core/sdl_checker.sv =====
// ----------------------------------------------------------------------------
// sdl_checker
// Port-level checks on the list core, bound to the core module.
// ----------------------------------------------------------------------------
module sdl_checker
    import sdl_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    // reset drops any pending response
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // one request in flight: next cycle is held off
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("second request taken while busy");

    // each accepted request is answered by a valid response
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |-> ##2 o_rsp_valid)
        else $error("response missing two cycles after request");

    // count stays within the depth, status code meaningful
    a_rsp_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status != 2'd3) &&
                        (32'(o_rsp.entry_count) <= LIST_DEPTH))
        else $error("response out of range");

endmodule

bind search_delete_list_core sdl_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_sdl_checker (.*);

// ===== dv/tb_search_delete_list_core.sv =====
// ----------------------------------------------------------------------------
// tb_search_delete_list_core
// Self-checking bench for the newest-first search/delete list core.
// A clocked driver presents requests from a pending queue. An internal list
// model predicts each response at its accept edge. A clocked monitor compares
// every response field by field against the oldest prediction. The directed
// opening covers the empty list, the extreme keys, duplicates and a full list.
// Random traffic follows in three idling phases, one with a long response
// hold-off.
// ----------------------------------------------------------------------------
module tb_search_delete_list_core;
    import sdl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF   = 5;
    localparam int LIST_DEPTH = DEF_LIST_DEPTH;
    localparam int LONG_HOLD  = 60;          // cycles of forced response stall
    localparam int POOL_MAX   = 24;          // recent keys kept for hits
    localparam int TIMEOUT_NS = 2_000_000;

    // action code with no operation behind it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] KEY_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] KEY_ZERO = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] KEY_ONES = 32'shFFFF_FFFF;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_stall = 1'b0;
    t_req i_req       = '0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // pending requests, predicted responses, recently inserted keys
    t_req                     pending_reqs[$];
    t_rsp                     expected_rsps[$];
    logic signed [DATA_W-1:0] key_pool[$];

    // list model: slot 0 is the head
    logic signed [DATA_W-1:0] model_keys[LIST_DEPTH];
    int                       model_count = 0;

    // idling, percent of cycles (written only by the stimulus process)
    int req_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int hold_asks     = 0;

    // monitor-owned
    int hold_served = 0;
    int hold_left   = 0;
    int error_count = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    search_delete_list_core #(
        .LIST_DEPTH (LIST_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    // Applies one request to the list model and returns its response.
    // A delete or search matches the entry nearest the head.
    function automatic t_rsp apply_list_op(t_req req);
        t_rsp rsp;
        int   hit;
        rsp.status      = ST_MISS;
        rsp.found_value = '0;
        hit             = -1;
        for (int i = 0; i < model_count; i++) begin
            if (hit < 0 && model_keys[i] == req.key_value) hit = i;
        end
        case (req.action)
            ACT_INSERT: begin
                if (model_count >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int i = model_count; i > 0; i--) model_keys[i] = model_keys[i-1];
                    model_keys[0] = req.key_value;
                    model_count++;
                    rsp.status = ST_DONE;
                end
            end
            ACT_DELETE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
                    model_count--;
                    rsp.status = ST_DONE;
                end
            end
            ACT_SEARCH: begin
                if (hit >= 0) begin
                    rsp.found_value = model_keys[hit];
                    rsp.status      = ST_DONE;
                end
            end
            default: begin
                // unused code: no change, reported as not found
            end
        endcase
        rsp.entry_count = ENTRY_W'(model_count);
        return rsp;
    endfunction

    function automatic void queue_req(logic [ACTION_W-1:0] act, logic signed [DATA_W-1:0] key);
        t_req r;
        r.action    = act;
        r.key_value = key;
        pending_reqs.push_back(r);
        if (act == ACT_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] special_key();
        case ($urandom_range(3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return KEY_ZERO;
            default: return KEY_ONES;
        endcase
    endfunction

    // Random traffic in segments of 40 requests, alternately insert-heavy
    // (pushes the list toward full) and delete-heavy (pulls it toward empty).
    // Deletes and searches mostly use recent keys so that they hit.
    task automatic queue_random_ops(int n);
        int                        r;
        int                        insert_pct;
        logic [ACTION_W-1:0]       act;
        logic signed [DATA_W-1:0]  key;
        for (int k = 0; k < n; k++) begin
            insert_pct = ((k / 40) % 2 == 0) ? 70 : 30;
            r = $urandom_range(99);
            if (r < 3)                  act = ACT_UNUSED;
            else if (r < insert_pct)    act = ACT_INSERT;
            else if (r[0])              act = ACT_DELETE;
            else                        act = ACT_SEARCH;
            r = $urandom_range(99);
            if (r < 12)
                key = special_key();
            else if (key_pool.size() != 0 && r < ((act == ACT_INSERT) ? 35 : 75))
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                key = $urandom;
            queue_req(act, key);
        end
    endtask

    // checked on the falling edge, once the driver and monitor have settled
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_req_valid || expected_rsps.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A request is taken at an edge with valid high and stall
    // low; its response is predicted there. A stalled request stays put, and
    // idle cycles are drawn independently of the stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        logic taken;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            taken = i_req_valid && !o_req_stall;
            if (taken) expected_rsps.push_back(apply_list_op(i_req));
            if (!i_req_valid || taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
                    i_req_valid <= 1'b1;
                    i_req       <= pending_reqs.pop_front();
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor and stall generator. A long hold-off, when asked for,
    // is counted down here, ahead of the random stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        t_rsp got;
        logic stall_nxt;
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                got = o_rsp;
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding: status %0d", got.status);
                    error_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, got.status);
                        error_count++;
                    end
                    if (got.found_value !== want.found_value) begin
                        $error("found_value mismatch: expected %0d, got %0d",
                               want.found_value, got.found_value);
                        error_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        error_count++;
                    end
                end
            end
            if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_nxt = 1'b1;
            end else begin
                stall_nxt = ($urandom_range(99) < rsp_stall_pct);
            end
            i_rsp_stall <= stall_nxt;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender idles a little, receiver a lot
        req_idle_pct  = 35;
        rsp_stall_pct = 85;

        // empty list: every lookup misses, unused code ignored
        queue_req(ACT_SEARCH, 32'sd7);
        queue_req(ACT_DELETE, 32'sd7);
        queue_req(ACT_UNUSED, KEY_ONES);
        // extreme keys, then a duplicate of zero
        queue_req(ACT_INSERT, KEY_MIN);
        queue_req(ACT_INSERT, KEY_MAX);
        queue_req(ACT_INSERT, KEY_ZERO);
        queue_req(ACT_INSERT, KEY_ONES);
        queue_req(ACT_INSERT, KEY_ZERO);
        queue_req(ACT_SEARCH, KEY_MIN);
        queue_req(ACT_SEARCH, KEY_ZERO);       // hit whose value is zero
        queue_req(ACT_DELETE, KEY_ZERO);       // removes the newer copy only
        queue_req(ACT_SEARCH, KEY_ZERO);
        queue_req(ACT_DELETE, 32'sd12345);     // miss on a non-empty list
        // fill to the brim, then insert into a full list
        for (int i = 0; i < LIST_DEPTH - 4; i++) queue_req(ACT_INSERT, $urandom);
        queue_req(ACT_INSERT, KEY_MAX);
        queue_req(ACT_DELETE, KEY_MIN);        // oldest entry sits at the tail

        queue_random_ops(130);
        wait_for_drain();

        // phase 2: roles swapped; the drain above is the sender's pause
        req_idle_pct  = 85;
        rsp_stall_pct = 35;
        queue_random_ops(150);
        wait_for_drain();

        // phase 3: no idling, opened by a long response hold-off so the core
        // backs up and stalls its request side
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        hold_asks     = hold_asks + 1;
        queue_random_ops(150);
        wait_for_drain();

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
